[hdl/ksl_pkg.sv]
// Shared types, defaults and codes for the keyed statistics lookup block.
`default_nettype none
package ksl_pkg;

  localparam int unsigned ENTRY_DEPTH_DEF = 4096;
  localparam int unsigned ID_DEPTH_DEF    = 16384;
  localparam int unsigned LIST_LIMIT_DEF  = 63;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned OWN_W   = 15;
  localparam int unsigned IDENT_W = 32;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned LIM_W   = 6;

  typedef enum logic [1:0] {
    FUNC_LOAD_ENTRY = 2'd0,
    FUNC_LOAD_ID    = 2'd1,
    FUNC_QUERY      = 2'd2,
    FUNC_NONE       = 2'd3
  } func_e;

  localparam logic KIND_STATS = 1'b0;
  localparam logic KIND_ID    = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] white;
    logic [CNT_W-1:0] black;
    logic [CNT_W-1:0] draw;
  } stats_t;

  typedef struct packed {
    logic               valid;
    logic               kind;
    logic               found;
    logic [INDEX_W-1:0] index;
    stats_t             stats;
    logic [IDENT_W-1:0] ident;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

[hdl/keyed_stats_lookup_with_id_list.sv]
// Keyed statistics lookup top level: command decode, list limit register, store and query units.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries commands: func 0 appends an
//    entry (keys in ascending order), func 1 appends an identifier, func 2 queries.
//  - Loads produce no result and are dropped once a table is full.
//  - A query runs a lower-bound binary search; each halving step is a search
//    state that reads the entry key memory and a probe state that compares the
//    registered key; the fetch, first-offset and limit states precede the statistics result.
//  - A match is followed by up to max_ids_listed identifier transfers, each an
//    identifier memory read, then output register; last marks the final result.
//  - One command is in work at a time; in_ready_o rises as soon as the last
//    result enters the output register, so the next command is taken while that
//    result waits on out_ready_i.
//  - A receiver stall holds the output register, and the query sequencer waits to load its next result.
//  - cfg_we_i writes max_ids_listed, capped at LIST_LIMIT; write only when idle.
//  - Reset empties both tables and sets max_ids_listed to LIST_LIMIT; no
//    clearing pass is needed.
`default_nettype none
module keyed_stats_lookup_with_id_list #(
  parameter int unsigned ENTRY_DEPTH = ksl_pkg::ENTRY_DEPTH_DEF,
  parameter int unsigned ID_DEPTH    = ksl_pkg::ID_DEPTH_DEF,
  parameter int unsigned LIST_LIMIT  = ksl_pkg::LIST_LIMIT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ksl_pkg::LIM_W-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  func_i,
  input  wire logic [ksl_pkg::KEY_W-1:0]   key_i,
  input  wire logic [ksl_pkg::CNT_W-1:0]   white_count_i,
  input  wire logic [ksl_pkg::CNT_W-1:0]   black_count_i,
  input  wire logic [ksl_pkg::CNT_W-1:0]   draw_count_i,
  input  wire logic [ksl_pkg::OWN_W-1:0]   owned_ids_i,
  input  wire logic [ksl_pkg::IDENT_W-1:0] ident_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             result_kind_o,
  output logic                             found_o,
  output logic [ksl_pkg::INDEX_W-1:0]      entry_index_o,
  output logic [ksl_pkg::CNT_W-1:0]        white_total_o,
  output logic [ksl_pkg::CNT_W-1:0]        black_total_o,
  output logic [ksl_pkg::CNT_W-1:0]        draw_total_o,
  output logic [ksl_pkg::IDENT_W-1:0]      listed_id_o,
  output logic                             last_o
);
  import ksl_pkg::*;

  localparam int unsigned EAW = $clog2(ENTRY_DEPTH);
  localparam int unsigned ECW = $clog2(ENTRY_DEPTH + 1);
  localparam int unsigned IAW = $clog2(ID_DEPTH);
  localparam int unsigned OW  = $clog2(ID_DEPTH + 1);

  logic [LIM_W-1:0]   max_ids_q, max_ids_d;
  logic               xfer, busy;
  logic               ld_entry, ld_id, start;
  stats_t             ld_stats;
  logic               ent_rd_en;
  logic [EAW-1:0]     ent_rd_addr;
  logic [KEY_W-1:0]   ent_key;
  stats_t             ent_stats;
  logic [OW-1:0]      ent_end;
  logic [ECW-1:0]     ent_count;
  logic               id_rd_en;
  logic [IAW-1:0]     id_rd_addr;
  logic [IDENT_W-1:0] id_data;
  logic [OW-1:0]      id_count;
  result_t            res;

  assign max_ids_d = (cfg_wdata_i > LIM_W'(LIST_LIMIT)) ? LIM_W'(LIST_LIMIT) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ids_q <= LIM_W'(LIST_LIMIT);
    end else if (cfg_we_i) begin
      max_ids_q <= max_ids_d;
    end
  end

  assign in_ready_o = !busy;
  assign xfer       = in_valid_i && in_ready_o;
  assign ld_entry   = xfer && (func_i == FUNC_LOAD_ENTRY);
  assign ld_id      = xfer && (func_i == FUNC_LOAD_ID);
  assign start      = xfer && (func_i == FUNC_QUERY);
  assign ld_stats   = '{white: white_count_i, black: black_count_i, draw: draw_count_i};

  ksl_entry_store #(
    .ENTRY_DEPTH (ENTRY_DEPTH),
    .ID_DEPTH    (ID_DEPTH)
  ) u_entry_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_en_i    (ld_entry),
    .ld_key_i   (key_i),
    .ld_stats_i (ld_stats),
    .ld_owned_i (owned_ids_i),
    .rd_en_i    (ent_rd_en),
    .rd_addr_i  (ent_rd_addr),
    .rd_key_o   (ent_key),
    .rd_stats_o (ent_stats),
    .rd_end_o   (ent_end),
    .count_o    (ent_count)
  );

  ksl_id_store #(
    .ID_DEPTH (ID_DEPTH)
  ) u_id_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_en_i    (ld_id),
    .ld_ident_i (ident_i),
    .rd_en_i    (id_rd_en),
    .rd_addr_i  (id_rd_addr),
    .rd_ident_o (id_data),
    .count_o    (id_count)
  );

  ksl_query #(
    .ENTRY_DEPTH (ENTRY_DEPTH),
    .ID_DEPTH    (ID_DEPTH)
  ) u_query (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .key_i         (key_i),
    .busy_o        (busy),
    .ent_count_i   (ent_count),
    .id_count_i    (id_count),
    .max_ids_i     (max_ids_q),
    .ent_rd_en_o   (ent_rd_en),
    .ent_rd_addr_o (ent_rd_addr),
    .ent_key_i     (ent_key),
    .ent_stats_i   (ent_stats),
    .ent_end_i     (ent_end),
    .id_rd_en_o    (id_rd_en),
    .id_rd_addr_o  (id_rd_addr),
    .id_data_i     (id_data),
    .out_ready_i   (out_ready_i),
    .res_o         (res)
  );

  assign out_valid_o   = res.valid;
  assign result_kind_o = res.kind;
  assign found_o       = res.found;
  assign entry_index_o = res.index;
  assign white_total_o = res.stats.white;
  assign black_total_o = res.stats.black;
  assign draw_total_o  = res.stats.draw;
  assign listed_id_o   = res.ident;
  assign last_o        = res.last;

endmodule
`default_nettype wire

[hdl/ksl_entry_store.sv]
// Entry table: key, counts and end offset memories, fill count and running prefix sum.
`default_nettype none
module ksl_entry_store #(
  parameter int unsigned ENTRY_DEPTH = 4096,
  parameter int unsigned ID_DEPTH    = 16384,
  localparam int unsigned EAW = $clog2(ENTRY_DEPTH),
  localparam int unsigned ECW = $clog2(ENTRY_DEPTH + 1),
  localparam int unsigned OW  = $clog2(ID_DEPTH + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     ld_en_i,
  input  wire logic [ksl_pkg::KEY_W-1:0] ld_key_i,
  input  wire ksl_pkg::stats_t          ld_stats_i,
  input  wire logic [ksl_pkg::OWN_W-1:0] ld_owned_i,
  input  wire logic                     rd_en_i,
  input  wire logic [EAW-1:0]           rd_addr_i,
  output logic [ksl_pkg::KEY_W-1:0]     rd_key_o,
  output ksl_pkg::stats_t               rd_stats_o,
  output logic [OW-1:0]                 rd_end_o,
  output logic [ECW-1:0]                count_o
);
  import ksl_pkg::*;

  localparam int unsigned SW = ((OW > OWN_W) ? OW : OWN_W) + 1;

  logic [KEY_W-1:0] key_mem  [ENTRY_DEPTH];
  stats_t           stat_mem [ENTRY_DEPTH];
  logic [OW-1:0]    end_mem  [ENTRY_DEPTH];

  logic [ECW-1:0] count_q, count_d;
  logic [OW-1:0]  run_q, run_d;
  logic [SW-1:0]  sum;
  logic           wr_ok;

  assign wr_ok = ld_en_i && (count_q < ECW'(ENTRY_DEPTH));
  assign sum   = SW'(run_q) + SW'(ld_owned_i);

  always_comb begin
    count_d = count_q;
    run_d   = run_q;
    if (wr_ok) begin
      count_d = count_q + 1'b1;
      run_d   = (sum > SW'(ID_DEPTH)) ? OW'(ID_DEPTH) : OW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      run_q   <= '0;
    end else begin
      count_q <= count_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      key_mem[count_q[EAW-1:0]]  <= ld_key_i;
      stat_mem[count_q[EAW-1:0]] <= ld_stats_i;
      end_mem[count_q[EAW-1:0]]  <= run_d;
    end
    if (rd_en_i) begin
      rd_key_o   <= key_mem[rd_addr_i];
      rd_stats_o <= stat_mem[rd_addr_i];
      rd_end_o   <= end_mem[rd_addr_i];
    end
  end

  assign count_o = count_q;

endmodule
`default_nettype wire

[hdl/ksl_id_store.sv]
// Identifier table memory with its fill count.
`default_nettype none
module ksl_id_store #(
  parameter int unsigned ID_DEPTH = 16384,
  localparam int unsigned IAW = $clog2(ID_DEPTH),
  localparam int unsigned OW  = $clog2(ID_DEPTH + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       ld_en_i,
  input  wire logic [ksl_pkg::IDENT_W-1:0] ld_ident_i,
  input  wire logic                       rd_en_i,
  input  wire logic [IAW-1:0]             rd_addr_i,
  output logic [ksl_pkg::IDENT_W-1:0]     rd_ident_o,
  output logic [OW-1:0]                   count_o
);
  import ksl_pkg::*;

  logic [IDENT_W-1:0] id_mem [ID_DEPTH];
  logic [OW-1:0]      count_q, count_d;
  logic               wr_ok;

  assign wr_ok   = ld_en_i && (count_q < OW'(ID_DEPTH));
  assign count_d = wr_ok ? count_q + 1'b1 : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      id_mem[count_q[IAW-1:0]] <= ld_ident_i;
    end
    if (rd_en_i) begin
      rd_ident_o <= id_mem[rd_addr_i];
    end
  end

  assign count_o = count_q;

endmodule
`default_nettype wire

[hdl/ksl_query.sv]
// Query sequencer: lower-bound binary search, slice bounds, identifier listing, output register.
`default_nettype none
module ksl_query #(
  parameter int unsigned ENTRY_DEPTH = 4096,
  parameter int unsigned ID_DEPTH    = 16384,
  localparam int unsigned EAW = $clog2(ENTRY_DEPTH),
  localparam int unsigned ECW = $clog2(ENTRY_DEPTH + 1),
  localparam int unsigned IAW = $clog2(ID_DEPTH),
  localparam int unsigned OW  = $clog2(ID_DEPTH + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ksl_pkg::KEY_W-1:0]  key_i,
  output logic                            busy_o,
  input  wire logic [ECW-1:0]             ent_count_i,
  input  wire logic [OW-1:0]              id_count_i,
  input  wire logic [ksl_pkg::LIM_W-1:0]  max_ids_i,
  output logic                            ent_rd_en_o,
  output logic [EAW-1:0]                  ent_rd_addr_o,
  input  wire logic [ksl_pkg::KEY_W-1:0]  ent_key_i,
  input  wire ksl_pkg::stats_t            ent_stats_i,
  input  wire logic [OW-1:0]              ent_end_i,
  output logic                            id_rd_en_o,
  output logic [IAW-1:0]                  id_rd_addr_o,
  input  wire logic [ksl_pkg::IDENT_W-1:0] id_data_i,
  input  wire logic                       out_ready_i,
  output ksl_pkg::result_t                res_o
);
  import ksl_pkg::*;

  localparam int unsigned SW = EAW + 1;
  localparam int unsigned DW = (OW > LIM_W) ? OW : LIM_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PROBE,
    ST_FETCH,
    ST_FIRST,
    ST_CALC,
    ST_STAT,
    ST_LIST_RD,
    ST_LIST_OUT
  } state_e;

  state_e           state_q;
  logic [KEY_W-1:0] key_q;
  logic [EAW-1:0]   lo_q, hi_q, mid_q;
  logic             found_q;
  stats_t           stats_q;
  logic [OW-1:0]    first_q, stop_q, ptr_q;
  logic [LIM_W-1:0] cnt_q, rem_q;
  result_t          res_q;

  logic [SW-1:0]    mid_sum;
  logic [EAW-1:0]   mid;
  logic [OW-1:0]    stop_c, diff_c;
  logic [DW-1:0]    diff_w;
  logic [LIM_W-1:0] cnt_c;
  logic             out_free;
  logic             res_load;
  logic             match;

  assign mid_sum  = SW'(lo_q) + SW'(hi_q);
  assign mid      = mid_sum[SW-1:1];
  assign stop_c   = (stop_q > id_count_i) ? id_count_i : stop_q;
  assign diff_c   = (stop_c > first_q) ? stop_c - first_q : '0;
  assign diff_w   = DW'(diff_c);
  assign cnt_c    = (diff_w > DW'(max_ids_i)) ? max_ids_i : LIM_W'(diff_w);
  assign out_free = !res_q.valid || out_ready_i;
  assign res_load = out_free && ((state_q == ST_STAT) || (state_q == ST_LIST_OUT));
  assign match    = (ent_key_i == key_q);

  always_comb begin
    ent_rd_en_o   = 1'b0;
    ent_rd_addr_o = lo_q;
    id_rd_en_o    = 1'b0;
    id_rd_addr_o  = ptr_q[IAW-1:0];
    case (state_q)
      ST_SEARCH: begin
        ent_rd_en_o   = 1'b1;
        ent_rd_addr_o = (lo_q < hi_q) ? mid : lo_q;
      end
      ST_FETCH: begin
        ent_rd_en_o   = match && (lo_q != '0);
        ent_rd_addr_o = lo_q - 1'b1;
      end
      ST_LIST_RD: begin
        id_rd_en_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_q.valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_q.valid <= 1'b1;
      end else if (out_ready_i) begin
        res_q.valid <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            key_q <= key_i;
            lo_q  <= '0;
            if (ent_count_i == '0) begin
              found_q <= 1'b0;
              stats_q <= '0;
              cnt_q   <= '0;
              state_q <= ST_STAT;
            end else begin
              hi_q    <= EAW'(ent_count_i - 1'b1);
              state_q <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid;
            state_q <= ST_PROBE;
          end else begin
            state_q <= ST_FETCH;
          end
        end
        ST_PROBE: begin
          if (ent_key_i < key_q) begin
            lo_q <= mid_q + 1'b1;
          end else begin
            hi_q <= mid_q;
          end
          state_q <= ST_SEARCH;
        end
        ST_FETCH: begin
          if (match) begin
            found_q <= 1'b1;
            stats_q <= ent_stats_i;
            stop_q  <= ent_end_i;
            if (lo_q == '0) begin
              first_q <= '0;
              state_q <= ST_CALC;
            end else begin
              state_q <= ST_FIRST;
            end
          end else begin
            found_q <= 1'b0;
            stats_q <= '0;
            cnt_q   <= '0;
            state_q <= ST_STAT;
          end
        end
        ST_FIRST: begin
          first_q <= ent_end_i;
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          cnt_q   <= cnt_c;
          ptr_q   <= first_q;
          state_q <= ST_STAT;
        end
        ST_STAT: begin
          if (out_free) begin
            res_q.kind  <= KIND_STATS;
            res_q.found <= found_q;
            res_q.index <= INDEX_W'(lo_q);
            res_q.stats <= stats_q;
            res_q.ident <= '0;
            res_q.last  <= (cnt_q == '0);
            rem_q       <= cnt_q;
            state_q     <= (cnt_q == '0) ? ST_IDLE : ST_LIST_RD;
          end
        end
        ST_LIST_RD: begin
          state_q <= ST_LIST_OUT;
        end
        ST_LIST_OUT: begin
          if (out_free) begin
            res_q.kind  <= KIND_ID;
            res_q.found <= 1'b1;
            res_q.index <= INDEX_W'(lo_q);
            res_q.stats <= '0;
            res_q.ident <= id_data_i;
            res_q.last  <= (rem_q == LIM_W'(1));
            ptr_q       <= ptr_q + 1'b1;
            rem_q       <= rem_q - 1'b1;
            state_q     <= (rem_q == LIM_W'(1)) ? ST_IDLE : ST_LIST_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign res_o  = res_q;

endmodule
`default_nettype wire
